>>> design/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg: shared types and constants of the frame delay line
// Holds store geometry, item kind codes, the queued memory operation and the
// pointer advance helper.
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int FRAME_W   = 32;
  localparam int MAX_DELAY = 256;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int KIND_W    = 2;

  // Depth of the queues between front, back and the result port.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  localparam logic [CNT_W-1:0] DELAY_RST = CNT_W'(1);
  localparam logic [CNT_W-1:0] DELAY_MAX = CNT_W'(MAX_DELAY);

  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESET = 2'd3;

  // One store access: an optional read of the oldest frame, then an
  // optional write of the new frame.
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [FRAME_W-1:0] wr_data;
  } mem_op_t;

  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx,
                                                input logic [CNT_W-1:0]  eff);
    logic [CNT_W-1:0] nxt;
    nxt = {1'b0, idx} + CNT_W'(1);
    return (nxt >= eff) ? '0 : nxt[ADDR_W-1:0];
  endfunction

endpackage

>>> design/frame_delay_line.sv
// ----------------------------------------------------------------------------
// frame_delay_line: frame delay line over a circular store
// Top level joining the classifying front end, the operation queue and the
// store back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_push, in_full) carry in_kind and in_frame: a data
//   frame, an empty tick, a flush command or a reset command. A transaction
//   is taken whenever in_push is high and in_full is low, one per cycle.
//   Results appear as a queue: out_delayed_frame is valid while out_empty is
//   low and leaves on out_pop.
//   While priming, data frames are stored silently until cfg_delay_count
//   frames, clamped to 1..MAX_DELAY, are held; afterwards each data frame
//   yields the oldest frame. A flush arms a drain, and each later empty tick
//   yields one held frame until the held count is spent. Throughput is
//   one transaction per cycle while in_full is low, limited by the single
//   store port doing one read and one write per cycle. A stalled receiver
//   fills the result queue, then the operation queue, and only then raises
//   in_full. After reset the delay is one frame, all queues are empty and
//   priming restarts; the store is not cleared. Writing cfg_delay_count
//   restarts priming; the user must see it done only while the block is
//   idle, which the block itself leaves unchecked.
// ----------------------------------------------------------------------------
module frame_delay_line (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fdl_pkg::CNT_W-1:0]    cfg_delay_count,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [fdl_pkg::KIND_W-1:0]   in_kind,
  input  logic [fdl_pkg::FRAME_W-1:0]  in_frame,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [fdl_pkg::FRAME_W-1:0]  out_delayed_frame
);

  logic             accept;
  logic             op_valid;
  fdl_pkg::mem_op_t op;
  logic             cq_empty;
  logic             cq_pop;
  fdl_pkg::mem_op_t cq_head;

  assign accept = in_push && !in_full;

  fdl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_delay_count (cfg_delay_count),
    .accept          (accept),
    .in_kind         (in_kind),
    .in_frame        (in_frame),
    .op_valid        (op_valid),
    .op              (op)
  );

  fdl_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_valid),
    .push_op (op),
    .full    (in_full),
    .pop     (cq_pop),
    .empty   (cq_empty),
    .head    (cq_head)
  );

  fdl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .op_empty          (cq_empty),
    .op                (cq_head),
    .op_pop            (cq_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_delayed_frame (out_delayed_frame)
  );

endmodule

>>> design/fdl_front.sv
// ----------------------------------------------------------------------------
// fdl_front: item classification and pointer control
// Tracks priming, drain and both ring pointers, and turns each accepted item
// into at most one store operation for the back end.
// ----------------------------------------------------------------------------
module fdl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fdl_pkg::CNT_W-1:0]    cfg_delay_count,
  input  logic                         accept,
  input  logic [fdl_pkg::KIND_W-1:0]   in_kind,
  input  logic [fdl_pkg::FRAME_W-1:0]  in_frame,
  output logic                         op_valid,
  output fdl_pkg::mem_op_t             op
);

  logic [fdl_pkg::ADDR_W-1:0] ri_r, ri_nxt, wi_r, wi_nxt;
  logic                       prime_r, prime_nxt;
  logic [fdl_pkg::CNT_W-1:0]  held_r, held_nxt;
  logic                       drain_r, drain_nxt;
  logic [fdl_pkg::CNT_W-1:0]  left_r, left_nxt;
  logic [fdl_pkg::CNT_W-1:0]  delay_r;
  logic [fdl_pkg::CNT_W-1:0]  eff;

  // A delay of zero behaves as one; anything above the store is clamped.
  always_comb begin
    if (delay_r == '0) begin
      eff = fdl_pkg::CNT_W'(1);
    end else if (delay_r > fdl_pkg::DELAY_MAX) begin
      eff = fdl_pkg::DELAY_MAX;
    end else begin
      eff = delay_r;
    end
  end

  always_comb begin
    ri_nxt     = ri_r;
    wi_nxt     = wi_r;
    prime_nxt  = prime_r;
    held_nxt   = held_r;
    drain_nxt  = drain_r;
    left_nxt   = left_r;
    op.rd      = 1'b0;
    op.wr      = 1'b0;
    op.rd_addr = ri_r;
    op.wr_addr = wi_r;
    op.wr_data = in_frame;
    unique case (in_kind)
      fdl_pkg::KIND_DATA: begin
        op.wr  = 1'b1;
        wi_nxt = fdl_pkg::advance(wi_r, eff);
        if (prime_r) begin
          held_nxt = held_r + fdl_pkg::CNT_W'(1);
          if (held_nxt >= eff) begin
            prime_nxt = 1'b0;
          end
        end else begin
          op.rd  = 1'b1;
          ri_nxt = fdl_pkg::advance(ri_r, eff);
        end
      end
      fdl_pkg::KIND_TICK: begin
        if (drain_r) begin
          if (left_r == '0) begin
            drain_nxt = 1'b0;
          end else begin
            op.rd    = 1'b1;
            ri_nxt   = fdl_pkg::advance(ri_r, eff);
            left_nxt = left_r - fdl_pkg::CNT_W'(1);
          end
        end
      end
      fdl_pkg::KIND_FLUSH: begin
        drain_nxt = 1'b1;
        left_nxt  = held_r;
      end
      fdl_pkg::KIND_RESET: begin
        ri_nxt    = '0;
        wi_nxt    = '0;
        prime_nxt = 1'b1;
        held_nxt  = '0;
        drain_nxt = 1'b0;
        left_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  assign op_valid = accept && (op.rd || op.wr);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      ri_r    <= '0;
      wi_r    <= '0;
      prime_r <= 1'b1;
      held_r  <= '0;
      drain_r <= 1'b0;
      left_r  <= '0;
    end else if (accept) begin
      ri_r    <= ri_nxt;
      wi_r    <= wi_nxt;
      prime_r <= prime_nxt;
      held_r  <= held_nxt;
      drain_r <= drain_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= fdl_pkg::DELAY_RST;
    end else if (cfg_we) begin
      delay_r <= cfg_delay_count;
    end
  end

endmodule

>>> design/fdl_cmdq.sv
// ----------------------------------------------------------------------------
// fdl_cmdq: operation queue between front and back
// A small FIFO of store operations so that each side can stall on its own.
// ----------------------------------------------------------------------------
module fdl_cmdq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fdl_pkg::mem_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output fdl_pkg::mem_op_t head
);

  fdl_pkg::mem_op_t          q_r [fdl_pkg::Q_DEPTH];
  logic [fdl_pkg::Q_AW-1:0]  wp_r, rp_r;
  logic [fdl_pkg::Q_CW-1:0]  cnt_r;

  assign full  = (cnt_r == fdl_pkg::Q_CW'(fdl_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + fdl_pkg::Q_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + fdl_pkg::Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + fdl_pkg::Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - fdl_pkg::Q_CW'(1);
      end
    end
  end

endmodule

>>> design/fdl_back.sv
// ----------------------------------------------------------------------------
// fdl_back: frame store and result queue
// Carries out queued store operations, one per cycle while the result
// queue has room, and collects the read frames there for the output port.
// ----------------------------------------------------------------------------
module fdl_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         op_empty,
  input  fdl_pkg::mem_op_t             op,
  output logic                         op_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [fdl_pkg::FRAME_W-1:0]  out_delayed_frame
);

  logic [fdl_pkg::FRAME_W-1:0] store_r [fdl_pkg::MAX_DELAY];
  logic [fdl_pkg::FRAME_W-1:0] rd_data_r;
  logic                        rd_v_r;

  logic [fdl_pkg::FRAME_W-1:0] oq_r [fdl_pkg::Q_DEPTH];
  logic [fdl_pkg::Q_AW-1:0]    owp_r, orp_r;
  logic [fdl_pkg::Q_CW-1:0]    ocnt_r;
  logic                        oq_pop;

  // A read in flight already owns a result slot, so leave room for it too.
  assign op_pop = !op_empty &&
                  ((ocnt_r + fdl_pkg::Q_CW'(rd_v_r)) < fdl_pkg::Q_CW'(fdl_pkg::Q_DEPTH));

  // The read sees the entry as it was before this operation's write.
  always_ff @(posedge clk) begin
    if (op_pop && op.wr) begin
      store_r[op.wr_addr] <= op.wr_data;
    end
    if (op_pop && op.rd) begin
      rd_data_r <= store_r[op.rd_addr];
    end
  end

  assign out_empty         = (ocnt_r == '0);
  assign oq_pop            = out_pop && !out_empty;
  assign out_delayed_frame = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      oq_r[owp_r] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      rd_v_r <= op_pop && op.rd;
      if (rd_v_r) begin
        owp_r <= owp_r + fdl_pkg::Q_AW'(1);
      end
      if (oq_pop) begin
        orp_r <= orp_r + fdl_pkg::Q_AW'(1);
      end
      if (rd_v_r && !oq_pop) begin
        ocnt_r <= ocnt_r + fdl_pkg::Q_CW'(1);
      end else if (oq_pop && !rd_v_r) begin
        ocnt_r <= ocnt_r - fdl_pkg::Q_CW'(1);
      end
    end
  end

endmodule

>>> design/fdl_checker.sv
// ----------------------------------------------------------------------------
// fdl_checker: port-level checks of the frame delay line
// Watches reset behavior, queue flags and result stability at the ports.
// ----------------------------------------------------------------------------
module fdl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_push,
  input logic                         in_full,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic [fdl_pkg::FRAME_W-1:0]  out_delayed_frame
);

  // Reset drains every queue.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_rst_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input still full after reset");

  // Input can only fill up as a result of a taken transaction.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("in_full rose without an input transaction");

  // A waiting result stays put until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_delayed_frame)))
    else $error("waiting result changed or vanished");

endmodule

bind frame_delay_line fdl_checker u_fdl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_push           (in_push),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_delayed_frame (out_delayed_frame)
);

>>> sim/frame_delay_line_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_delay_line_test: self-checking testbench of the frame delay line
// Drives a table of directed transactions and then random phases, each
// under its own delay setting and idling pattern. Every accepted input steps
// a behavioral delay line kept here; each popped frame is compared with the
// next expected frame: the table's for typed rows, else the delay line's.
// ----------------------------------------------------------------------------
module frame_delay_line_test;
  import fdl_pkg::*;

  localparam int NUM_PHASES     = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame;
    logic               typed;
    logic               has_res;
    logic [FRAME_W-1:0] res;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_delay_count;
  logic                 in_push;
  logic                 in_full;
  logic [KIND_W-1:0]    in_kind;
  logic [FRAME_W-1:0]   in_frame;
  logic                 out_empty;
  logic                 out_pop;
  logic [FRAME_W-1:0]   out_delayed_frame;

  // Behavioral copy of the delay line.
  logic [FRAME_W-1:0]   line_store [MAX_DELAY];
  bit                   written_map [MAX_DELAY];
  logic [ADDR_W-1:0]    rd_ptr;
  logic [ADDR_W-1:0]    wr_ptr;
  logic                 priming;
  logic [CNT_W-1:0]     held_frames;
  logic                 drain_armed;
  logic [CNT_W-1:0]     drain_left;
  logic [CNT_W-1:0]     line_delay;

  logic [FRAME_W-1:0]   pending_frames [$];
  int                   mismatch_count = 0;
  int                   sent_count = 0;
  int                   checked_count = 0;
  int                   tx_idle_pct = 0;
  int                   rx_stall_pct = 0;
  bit                   rx_hold_req = 0;

  int phase_delay [NUM_PHASES] = '{0, 2, 256, 3, 511, 1, -1, 5, -1, 257};
  int phase_items [NUM_PHASES] = '{100, 160, 380, 110, 380, 100, 120, 120, 140, 330};
  int phase_mode  [NUM_PHASES] = '{0, 0, 1, 2, 3, 1, 2, 3, 0, 1};

  dir_row_t directed_rows [22] = '{
    '{KIND_DATA,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_DATA,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{KIND_DATA,  32'hA5A5_A5A5, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{KIND_TICK,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_FLUSH, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_TICK,  32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_A5A5},
    '{KIND_TICK,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_DATA,  32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0000_0000},
    '{KIND_FLUSH, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{KIND_DATA,  32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
    '{KIND_TICK,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{KIND_TICK,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{KIND_RESET, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_DATA,  32'h0000_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_FLUSH, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_TICK,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_FFFF},
    '{KIND_TICK,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_DATA,  32'hFFFF_0000, 1'b1, 1'b1, 32'h0000_FFFF},
    '{KIND_TICK,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_FLUSH, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{KIND_TICK,  32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_0000},
    '{KIND_TICK,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}
  };

  frame_delay_line uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_delay_count   (cfg_delay_count),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_frame          (in_frame),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_delayed_frame (out_delayed_frame)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A delay of zero acts as one, and anything beyond the store as its size.
  function automatic logic [CNT_W-1:0] eff_delay();
    if (line_delay == '0) return CNT_W'(1);
    if (line_delay > DELAY_MAX) return DELAY_MAX;
    return line_delay;
  endfunction

  function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] idx);
    logic [CNT_W-1:0] nxt;
    nxt = {1'b0, idx} + CNT_W'(1);
    return (nxt >= eff_delay()) ? '0 : nxt[ADDR_W-1:0];
  endfunction

  function automatic void restart_line();
    rd_ptr      = '0;
    wr_ptr      = '0;
    priming     = 1'b1;
    held_frames = '0;
    drain_armed = 1'b0;
    drain_left  = '0;
  endfunction

  function automatic void store_frame(input logic [FRAME_W-1:0] frm);
    line_store[wr_ptr]  = frm;
    written_map[wr_ptr] = 1'b1;
    wr_ptr = next_index(wr_ptr);
  endfunction

  function automatic logic [FRAME_W-1:0] take_oldest();
    logic [FRAME_W-1:0] v;
    v = line_store[rd_ptr];
    rd_ptr = next_index(rd_ptr);
    return v;
  endfunction

  // Advances the delay line by one transaction; returns 1 when it emits a frame.
  function automatic bit delay_line_step(input logic [KIND_W-1:0] kind,
                                         input logic [FRAME_W-1:0] frm,
                                         output logic [FRAME_W-1:0] res);
    res = '0;
    case (kind)
      KIND_DATA: begin
        if (priming) begin
          store_frame(frm);
          held_frames = held_frames + CNT_W'(1);
          if (held_frames >= eff_delay()) priming = 1'b0;
          return 1'b0;
        end
        res = take_oldest();
        store_frame(frm);
        return 1'b1;
      end
      KIND_TICK: begin
        if (!drain_armed) return 1'b0;
        if (drain_left == '0) begin
          drain_armed = 1'b0;
          return 1'b0;
        end
        res = take_oldest();
        drain_left = drain_left - CNT_W'(1);
        return 1'b1;
      end
      KIND_FLUSH: begin
        drain_armed = 1'b1;
        drain_left  = held_frames;
        return 1'b0;
      end
      default: begin
        restart_line();
        return 1'b0;
      end
    endcase
  endfunction

  task automatic push_item(input logic [KIND_W-1:0] kind, input logic [FRAME_W-1:0] frm);
    in_push  <= 1'b1;
    in_kind  <= kind;
    in_frame <= frm;
    do @(posedge clk); while (in_full !== 1'b0);
    sent_count++;
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Stops offering and waits for every predicted frame, plus time for any
  // transaction still in flight that produces nothing.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_delay(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_we          <= 1'b1;
    cfg_delay_count <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    line_delay  = value;
    restart_line();
  endtask

  // Receiver: checks each popped frame and stalls as the current phase asks.
  initial begin
    int hold_left;
    logic [FRAME_W-1:0] exp_frame;
    hold_left = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pending_frames.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected delayed_frame, expected none, actual %h",
                   $time, out_delayed_frame);
        end else begin
          exp_frame = pending_frames.pop_front();
          checked_count++;
          if (out_delayed_frame !== exp_frame) begin
            mismatch_count++;
            $display("%0t: delayed_frame mismatch, expected %h, actual %h",
                     $time, exp_frame, out_delayed_frame);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
        out_pop    <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, quiet);
    $display("Mismatches found");
    $finish;
  end

  // Sender: directed table, then random phases under changing delays.
  initial begin
    logic [FRAME_W-1:0] res;
    logic [FRAME_W-1:0] frm;
    logic [KIND_W-1:0]  kind;
    bit                 has;
    int                 r;
    int                 dval;
    int                 data_pct;
    int                 tick_pct;
    int                 flush_pct;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_delay_count <= '0;
    in_push         <= 1'b0;
    in_kind         <= KIND_DATA;
    in_frame        <= '0;
    line_delay       = DELAY_RST;
    restart_line();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].kind, directed_rows[i].frame);
      has = delay_line_step(directed_rows[i].kind, directed_rows[i].frame, res);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].has_res) pending_frames.push_back(directed_rows[i].res);
      end else if (has) begin
        pending_frames.push_back(res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      dval = (phase_delay[p] < 0) ? $urandom_range(64, 1) : phase_delay[p];
      set_delay(CNT_W'(dval));
      case (phase_mode[p])
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 57; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 57; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      // Long delays need long runs of data to finish priming, so no resets.
      if (eff_delay() > CNT_W'(16)) begin
        data_pct = 80; tick_pct = 94; flush_pct = 100;
      end else begin
        data_pct = 66; tick_pct = 86; flush_pct = 96;
      end
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 1 && i == 60) rx_hold_req = 1'b1;
        if (p == 5 && i == 50) begin
          in_push <= 1'b0;
          while (pending_frames.size() != 0) @(posedge clk);
        end else begin
          sender_gap();
        end
        r = $urandom_range(99);
        if (r < data_pct) kind = KIND_DATA;
        else if (r < tick_pct) kind = KIND_TICK;
        else if (r < flush_pct) kind = KIND_FLUSH;
        else kind = KIND_RESET;
        // A repeated drain must not reach store entries never written.
        if (kind == KIND_TICK && drain_armed && drain_left != '0 && !written_map[rd_ptr])
          kind = KIND_DATA;
        case ($urandom_range(7))
          0: frm = '0;
          1: frm = '1;
          default: frm = $urandom;
        endcase
        push_item(kind, frm);
        if (delay_line_step(kind, frm, res)) pending_frames.push_back(res);
      end
    end

    in_push <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Covered %0d transactions and %0d delayed frames over %0d delay settings,",
             sent_count, checked_count, NUM_PHASES + 1);
    $display("with zero and oversized delays, drains, reset commands and a full stall.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
